>>> hw/rtl/hce_pkg.sv
`default_nettype none

package hce_pkg;

  localparam int BLOCK_SIZE   = 4;
  localparam int IDX_W        = 5;
  localparam int KEY_W        = 20;
  localparam int CHAR_W       = 8;
  localparam int OUT_W        = 7;
  localparam int NUM_KEY_ROWS = 4;
  localparam int FILL_W       = $clog2(BLOCK_SIZE);
  localparam int SUM_W        = 2 * IDX_W + FILL_W;

  localparam int MOD_LETTERS  = 26;
  localparam int RECIP_SHIFT  = 16;
  localparam int RECIP        = (2 ** RECIP_SHIFT + MOD_LETTERS - 1) / MOD_LETTERS;

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;

  localparam logic [1:0] REG_KEY_ROW_ZERO  = 2'd0;
  localparam logic [1:0] REG_KEY_ROW_ONE   = 2'd1;
  localparam logic [1:0] REG_KEY_ROW_TWO   = 2'd2;
  localparam logic [1:0] REG_KEY_ROW_THREE = 2'd3;

  localparam logic [KEY_W-1:0] KEY_ROW_ZERO_RST  = 20'd437481;
  localparam logic [KEY_W-1:0] KEY_ROW_ONE_RST   = 20'd201956;
  localparam logic [KEY_W-1:0] KEY_ROW_TWO_RST   = 20'd309922;
  localparam logic [KEY_W-1:0] KEY_ROW_THREE_RST = 20'd284387;

  typedef logic [IDX_W-1:0] letter_t;

  typedef struct packed {
    letter_t [BLOCK_SIZE-1:0] letters;
    logic                     msg_end;
  } block_t;

  typedef logic [BLOCK_SIZE-1:0][KEY_W-1:0] key_mat_t;

  // {is_letter, index}
  function automatic logic [IDX_W:0] fold_letter(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    logic [IDX_W:0]    r;
    r = '0;
    if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
      d = c - ASCII_UPPER_A;
      r = {1'b1, d[IDX_W-1:0]};
    end else if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
      d = c - ASCII_LOWER_A;
      r = {1'b1, d[IDX_W-1:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hce_front.sv
`default_nettype none

module hce_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [hce_pkg::CHAR_W-1:0] char_in,
  input  wire logic                       message_end,
  input  wire logic                       queue_full,
  output logic                            push,
  output hce_pkg::block_t                 push_blk
);

  logic [hce_pkg::FILL_W-1:0] fill;
  logic [hce_pkg::FILL_W-1:0] fill_next;
  hce_pkg::letter_t [hce_pkg::BLOCK_SIZE-2:0] pending;
  hce_pkg::letter_t [hce_pkg::BLOCK_SIZE-2:0] pending_next;

  logic [hce_pkg::IDX_W:0]    folded;
  logic                       have;
  hce_pkg::letter_t           idx;
  logic [hce_pkg::FILL_W:0]   cnt_next;
  logic                       full_hit;
  logic                       push_req;
  logic                       accept;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign folded   = hce_pkg::fold_letter(char_in);
  assign have     = folded[hce_pkg::IDX_W];
  assign idx      = folded[hce_pkg::IDX_W-1:0];
  assign cnt_next = {1'b0, fill} + {{hce_pkg::FILL_W{1'b0}}, have};
  assign full_hit = have && (fill == hce_pkg::FILL_W'(hce_pkg::BLOCK_SIZE - 1));
  assign push_req = full_hit || (message_end && (cnt_next != '0));
  assign fill_next = push_req ? '0 : cnt_next[hce_pkg::FILL_W-1:0];
  assign push     = accept && push_req;

  always_comb begin
    for (int i = 0; i < hce_pkg::BLOCK_SIZE - 1; i++) begin
      pending_next[i] = (have && fill == hce_pkg::FILL_W'(i)) ? idx : pending[i];
      push_blk.letters[i] = ((hce_pkg::FILL_W+1)'(i) < cnt_next) ? pending_next[i] : '0;
    end
    push_blk.letters[hce_pkg::BLOCK_SIZE-1] = full_hit ? idx : '0;
    push_blk.msg_end = message_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pending <= pending_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hce_queue.sv
`default_nettype none

module hce_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  hce_pkg::block_t       wr_blk,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output hce_pkg::block_t       head
);

  hce_pkg::block_t            mem [hce_pkg::QUEUE_DEPTH];
  logic [hce_pkg::QPTR_W-1:0] wr_ptr;
  logic [hce_pkg::QPTR_W-1:0] rd_ptr;
  logic [hce_pkg::QPTR_W:0]   count;

  assign full       = (count == (hce_pkg::QPTR_W+1)'(hce_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_blk;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hce_back.sv
`default_nettype none

module hce_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      head_valid,
  input  hce_pkg::block_t                head,
  output logic                           pop,
  input  hce_pkg::key_mat_t              key,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [hce_pkg::OUT_W-1:0]      cipher_char,
  output logic                           block_last,
  output logic                           message_last
);

  localparam int PROD_W = hce_pkg::SUM_W + hce_pkg::RECIP_SHIFT;

  logic [hce_pkg::FILL_W-1:0] row;
  logic                       row_last;
  logic                       out_go;
  logic                       s1_go;
  logic                       take;

  logic [hce_pkg::SUM_W-1:0]  sum;
  logic                       s1_vld;
  logic [hce_pkg::SUM_W-1:0]  s1_sum;
  logic                       s1_blast;
  logic                       s1_mlast;

  logic [PROD_W-1:0]          prod;
  logic [hce_pkg::SUM_W-1:0]  quo;
  logic [hce_pkg::SUM_W-1:0]  quo26;
  logic [hce_pkg::SUM_W-1:0]  rem;

  assign row_last = (row == hce_pkg::FILL_W'(hce_pkg::BLOCK_SIZE - 1));
  assign out_go   = !out_valid || !out_stall;
  assign s1_go    = !s1_vld || out_go;
  assign take     = head_valid && s1_go;
  assign pop      = take && row_last;

  always_comb begin
    sum = '0;
    for (int k = 0; k < hce_pkg::BLOCK_SIZE; k++) begin
      sum = sum + hce_pkg::SUM_W'(key[row][k*hce_pkg::IDX_W +: hce_pkg::IDX_W])
                * hce_pkg::SUM_W'(head.letters[k]);
    end
  end

  // mod 26 by reciprocal
  assign prod  = PROD_W'(s1_sum) * PROD_W'(hce_pkg::RECIP);
  assign quo   = prod[hce_pkg::RECIP_SHIFT +: hce_pkg::SUM_W];
  assign quo26 = (quo << 4) + (quo << 3) + (quo << 1);
  assign rem   = s1_sum - quo26;

  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      s1_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        row <= row_last ? '0 : row + 1'b1;
      end
      if (s1_go) begin
        s1_vld <= take;
      end
      if (out_go) begin
        out_valid <= s1_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_sum   <= sum;
      s1_blast <= row_last;
      s1_mlast <= row_last && head.msg_end;
    end
    if (out_go && s1_vld) begin
      cipher_char  <= hce_pkg::ASCII_LOWER_A[hce_pkg::OUT_W-1:0]
                    + hce_pkg::OUT_W'(rem);
      block_last   <= s1_blast;
      message_last <= s1_mlast;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hill_cipher_encrypt_4x4.sv
// A completed block enters the queue; its letters then pass the sum and output registers.
// Throughput: one character per cycle unless the queue is full; blocks leave at one letter
//   per cycle unless out_stall is high, as the back end has a single row-product unit.
// A message end that flushes a partial block pads it with zero letters to a full block.
// Reset (synchronous, rst high): fill count, queue and pipeline cleared; key rows
//   return to their default values.
`default_nettype none

module hill_cipher_encrypt_4x4 (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [hce_pkg::CHAR_W-1:0]     char_in,
  input  wire logic                           message_end,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [hce_pkg::OUT_W-1:0]           cipher_char,
  output logic                                block_last,
  output logic                                message_last,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [hce_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [hce_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [hce_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  logic [hce_pkg::NUM_KEY_ROWS-1:0][hce_pkg::KEY_W-1:0] key_rows;
  hce_pkg::key_mat_t key;
  logic [1:0]        reg_sel;
  logic              cfg_wr;

  logic              push;
  hce_pkg::block_t   push_blk;
  logic              queue_full;
  logic              head_valid;
  hce_pkg::block_t   head;
  logic              pop;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_rows[hce_pkg::REG_KEY_ROW_ZERO]  <= hce_pkg::KEY_ROW_ZERO_RST;
      key_rows[hce_pkg::REG_KEY_ROW_ONE]   <= hce_pkg::KEY_ROW_ONE_RST;
      key_rows[hce_pkg::REG_KEY_ROW_TWO]   <= hce_pkg::KEY_ROW_TWO_RST;
      key_rows[hce_pkg::REG_KEY_ROW_THREE] <= hce_pkg::KEY_ROW_THREE_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        hce_pkg::REG_KEY_ROW_ZERO:  key_rows[hce_pkg::REG_KEY_ROW_ZERO]  <= pwdata[hce_pkg::KEY_W-1:0];
        hce_pkg::REG_KEY_ROW_ONE:   key_rows[hce_pkg::REG_KEY_ROW_ONE]   <= pwdata[hce_pkg::KEY_W-1:0];
        hce_pkg::REG_KEY_ROW_TWO:   key_rows[hce_pkg::REG_KEY_ROW_TWO]   <= pwdata[hce_pkg::KEY_W-1:0];
        hce_pkg::REG_KEY_ROW_THREE: key_rows[hce_pkg::REG_KEY_ROW_THREE] <= pwdata[hce_pkg::KEY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      hce_pkg::REG_KEY_ROW_ZERO:  prdata[hce_pkg::KEY_W-1:0] = key_rows[hce_pkg::REG_KEY_ROW_ZERO];
      hce_pkg::REG_KEY_ROW_ONE:   prdata[hce_pkg::KEY_W-1:0] = key_rows[hce_pkg::REG_KEY_ROW_ONE];
      hce_pkg::REG_KEY_ROW_TWO:   prdata[hce_pkg::KEY_W-1:0] = key_rows[hce_pkg::REG_KEY_ROW_TWO];
      hce_pkg::REG_KEY_ROW_THREE: prdata[hce_pkg::KEY_W-1:0] = key_rows[hce_pkg::REG_KEY_ROW_THREE];
      default: ;
    endcase
  end

  always_comb begin
    for (int r = 0; r < hce_pkg::BLOCK_SIZE; r++) begin
      key[r] = key_rows[r];
    end
  end

  hce_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_in     (char_in),
    .message_end (message_end),
    .queue_full  (queue_full),
    .push        (push),
    .push_blk    (push_blk)
  );

  hce_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_blk     (push_blk),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  hce_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .key          (key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cipher_char  (cipher_char),
    .block_last   (block_last),
    .message_last (message_last)
  );

endmodule

`default_nettype wire

>>> hw/rtl/hce_checker.sv
`default_nettype none

module hce_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [hce_pkg::OUT_W-1:0]  cipher_char,
  input wire logic                       block_last,
  input wire logic                       message_last
);

  a_rst_out_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_rst_in_open: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

  a_letter_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cipher_char >= hce_pkg::ASCII_LOWER_A[hce_pkg::OUT_W-1:0]
                && cipher_char <= hce_pkg::ASCII_LOWER_Z[hce_pkg::OUT_W-1:0]))
    else $error("cipher letter out of range");

  a_msg_on_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_last |-> block_last)
    else $error("message end not on block end");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cipher_char))
    else $error("stalled item changed");

endmodule

bind hill_cipher_encrypt_4x4 hce_checker u_hce_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .cipher_char  (cipher_char),
  .block_last   (block_last),
  .message_last (message_last)
);

`default_nettype wire

>>> sim/hill_cipher_encrypt_4x4_tb.sv
`timescale 1ns / 1ps

package hce_tb_pkg;
  import hce_pkg::*;

  typedef logic [OUT_W-1:0] cipher_t;

  typedef struct packed {
    cipher_t ch;
    logic    blk_last;
    logic    msg_last;
  } cipher_letter_t;

  class hill_scoreboard;
    logic [KEY_W-1:0] key_row [NUM_KEY_ROWS];
    letter_t          held [BLOCK_SIZE-1];
    int               fill;
    cipher_letter_t   expected_letters [$];
    int errors, chars, letters, blocks, flushes;

    function new();
      key_row[REG_KEY_ROW_ZERO]  = KEY_ROW_ZERO_RST;
      key_row[REG_KEY_ROW_ONE]   = KEY_ROW_ONE_RST;
      key_row[REG_KEY_ROW_TWO]   = KEY_ROW_TWO_RST;
      key_row[REG_KEY_ROW_THREE] = KEY_ROW_THREE_RST;
      fill = 0;
    endfunction

    function void set_key(logic [1:0] row, logic [KEY_W-1:0] v);
      key_row[row] = v;
    endfunction

    function void encrypt_block(letter_t [BLOCK_SIZE-1:0] blk, logic end_msg);
      int acc;
      cipher_letter_t r;
      for (int j = 0; j < BLOCK_SIZE; j++) begin
        acc = 0;
        for (int k = 0; k < BLOCK_SIZE; k++)
          acc += int'(key_row[j][k*IDX_W +: IDX_W]) * int'(blk[k]);
        r.ch       = cipher_t'(int'(ASCII_LOWER_A) + acc % MOD_LETTERS);
        r.blk_last = (j == BLOCK_SIZE - 1);
        r.msg_last = end_msg && (j == BLOCK_SIZE - 1);
        expected_letters.push_back(r);
      end
    endfunction

    // predicts the letters caused by one accepted character
    function void take_char(logic [CHAR_W-1:0] c, logic end_msg);
      letter_t [BLOCK_SIZE-1:0] blk;
      letter_t idx;
      logic    is_letter;
      chars++;
      is_letter = 1'b1;
      if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z)
        idx = letter_t'(c - ASCII_UPPER_A);
      else if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z)
        idx = letter_t'(c - ASCII_LOWER_A);
      else
        is_letter = 1'b0;
      if (is_letter) begin
        if (fill == BLOCK_SIZE - 1) begin
          for (int i = 0; i < BLOCK_SIZE - 1; i++)
            blk[i] = held[i];
          blk[BLOCK_SIZE-1] = idx;
          fill = 0;
          encrypt_block(blk, end_msg);
          return;
        end
        held[fill] = idx;
        fill++;
      end
      if (end_msg && fill > 0) begin
        for (int i = 0; i < BLOCK_SIZE; i++)
          blk[i] = (i < fill) ? held[i] : letter_t'(0);
        fill = 0;
        flushes++;
        encrypt_block(blk, 1'b1);
      end
    endfunction

    function void check_letter(cipher_t ch, logic bl, logic ml);
      cipher_letter_t e;
      if (expected_letters.size() == 0) begin
        $error("unexpected letter %0d (block_last %0b message_last %0b)", ch, bl, ml);
        errors++;
        return;
      end
      e = expected_letters.pop_front();
      letters++;
      if (bl)
        blocks++;
      if (ch !== e.ch) begin
        $error("cipher_char: expected %0d, got %0d", e.ch, ch);
        errors++;
      end
      if (bl !== e.blk_last) begin
        $error("block_last: expected %0b, got %0b", e.blk_last, bl);
        errors++;
      end
      if (ml !== e.msg_last) begin
        $error("message_last: expected %0b, got %0b", e.msg_last, ml);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_letters.size();
    endfunction
  endclass
endpackage

module hill_cipher_encrypt_4x4_tb;
  import hce_pkg::*;
  import hce_tb_pkg::*;

  localparam int REG_STRIDE    = 4;
  localparam int HOLD_CYCLES   = 60;
  localparam int PHASE_ITEMS   = 74;
  localparam int NUM_PHASES    = 6;
  localparam int SETTLE_CYCLES = 12;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CHAR_W-1:0]     char_in = '0;
  logic                  message_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_W-1:0]      cipher_char;
  logic                  block_last;
  logic                  message_last;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  hill_scoreboard sb = new();

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int key_settings = 0;

  hill_cipher_encrypt_4x4 DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_in     (char_in),
    .message_end (message_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cipher_char (cipher_char),
    .block_last  (block_last),
    .message_last(message_last),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.take_char(char_in, message_end);
      if (out_valid && !out_stall)
        sb.check_letter(cipher_char, block_last, message_last);
    end
  end

  task automatic apb_write(input logic [1:0] row, input logic [KEY_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(REG_STRIDE * row);
    pwdata  <= CFG_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    sb.set_key(row, v);
  endtask

  task automatic check_key_readback();
    logic [CFG_DATA_W-1:0] got;
    for (int r = 0; r < NUM_KEY_ROWS; r++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CFG_ADDR_W'(REG_STRIDE * r);
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
      if (got !== CFG_DATA_W'(sb.key_row[r])) begin
        $error("key row %0d readback: expected %0h, got %0h", r, sb.key_row[r], got);
        sb.errors++;
      end
    end
  endtask

  task automatic load_key(input logic [KEY_W-1:0] r0, input logic [KEY_W-1:0] r1,
                          input logic [KEY_W-1:0] r2, input logic [KEY_W-1:0] r3);
    apb_write(REG_KEY_ROW_ZERO, r0);
    apb_write(REG_KEY_ROW_ONE, r1);
    apb_write(REG_KEY_ROW_TWO, r2);
    apb_write(REG_KEY_ROW_THREE, r3);
    key_settings++;
    check_key_readback();
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic e);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    char_in     <= c;
    message_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    return KEY_W'($urandom);
  endfunction

  initial begin
    logic [CHAR_W:0]   directed [$];
    logic [CHAR_W-1:0] c;
    logic              e;
    int                tx_pct [NUM_PHASES];
    int                rx_pct [NUM_PHASES];

    directed = '{{1'b0, "A"}, {1'b0, 8'h40}, {1'b0, "Z"}, {1'b0, 8'h5B},
                 {1'b0, "a"}, {1'b0, 8'h60}, {1'b0, "z"},
                 {1'b1, 8'h00},
                 {1'b1, "m"},
                 {1'b0, "b"}, {1'b1, "C"},
                 {1'b0, "Q"}, {1'b0, 8'h7B}, {1'b0, "r"}, {1'b1, "S"},
                 {1'b0, "w"}, {1'b0, "x"}, {1'b0, "y"}, {1'b1, "Z"},
                 {1'b0, "k"}, {1'b1, 8'hFF},
                 {1'b0, 8'h80}, {1'b1, 8'h7F}};
    tx_pct = '{0, 52, 0, 22, 0, 22};
    rx_pct = '{0, 0, 52, 22, 0, 22};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_key_readback();

    foreach (directed[i])
      send_char(directed[i][CHAR_W-1:0], directed[i][CHAR_W]);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: load_key('1, '1, '1, '1);
        2: load_key('0, '0, '0, '0);
        default: load_key(rand_key(), rand_key(), rand_key(), rand_key());
      endcase
      tx_idle_pct = tx_pct[ph];
      rx_stall_pct <= rx_pct[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // phase 4: long receiver hold-off while characters keep coming
        if (ph == 4 && n == 5)
          hold_reqs <= hold_reqs + 1;
        if ($urandom_range(99) < 72) begin
          c = ($urandom_range(1) ? ASCII_UPPER_A : ASCII_LOWER_A) + CHAR_W'($urandom_range(25));
        end else begin
          c = CHAR_W'($urandom_range(255));
        end
        e = ($urandom_range(99) < 9);
        send_char(c, e);
      end
      drain();
      rx_stall_pct <= 0;
    end

    $display("Covered %0d characters and %0d ciphertext letters in %0d blocks",
             sb.chars, sb.letters, sb.blocks);
    $display("  (%0d padded flushes) across %0d key settings and four idling modes",
             sb.flushes, key_settings);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $error("timed out with %0d letters still expected", sb.outstanding());
    $display("== FAIL ==");
    $finish;
  end

endmodule
